// File: hdl/dfr_pkg.sv
// Shared types, widths and command encodings for the deferred free reclaimer.
// No dependencies; every other file imports this package.
package dfr_pkg;

	localparam int READER_DEPTH  = 16;
	localparam int PENDING_DEPTH = 32;
	localparam int MAX_RESULTS   = 32;

	localparam int ID_W   = 16;
	localparam int STEP_W = 64;
	localparam int HDL_W  = 64;

	localparam int RCW = $clog2(READER_DEPTH + 1);
	localparam int PCW = $clog2(PENDING_DEPTH + 1);
	localparam int RIW = (READER_DEPTH > 1) ? $clog2(READER_DEPTH) : 1;
	localparam int PIW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

	typedef enum logic [1:0] {
		OPC_START = 2'd0,
		OPC_END   = 2'd1,
		OPC_FREE  = 2'd2,
		OPC_RSVD  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_REL   = 2'd1,
		STS_RFULL = 2'd2,
		STS_PFULL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		HS_ZERO,
		HS_IN,
		HS_MEM
	} hsel_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_R_RD_PREV,
		DP_R_SHIFT,
		DP_R_INS,
		DP_P_RD_PREV,
		DP_P_SHIFT,
		DP_P_INS,
		DP_R_RD,
		DP_R_NEXT,
		DP_R_RD_NEXT,
		DP_R_PULL,
		DP_R_DEC,
		DP_R_RD0,
		DP_EARL,
		DP_P_DEC,
		DP_P_SETN,
		DP_P_RD,
		DP_P_EMIT,
		DP_P_PULL,
		DP_P_TRIM
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISP,
		ST_RI_RD,
		ST_RI_CMP,
		ST_RI_WR,
		ST_PI_RD,
		ST_PI_CMP,
		ST_PI_WR,
		ST_E_RD,
		ST_E_CMP,
		ST_E_DEL,
		ST_E_DEL_WR,
		ST_E_EARL,
		ST_E_EARL_LD,
		ST_P_SCAN,
		ST_P_SCMP,
		ST_P_CNT,
		ST_P_RD,
		ST_P_EMIT,
		ST_P_CP,
		ST_P_CPW
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [STEP_W-1:0] step;
	} rrow_t;

	typedef struct packed {
		logic [STEP_W-1:0] step;
		logic [HDL_W-1:0]  hdl;
	} prow_t;

	typedef struct packed {
		dp_op_t  op;
		logic    emit;
		status_t e_status;
		hsel_t   e_hsel;
		logic    e_last;
	} dp_cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    rcnt_zero;
		logic    rfull;
		logic    pfull;
		logic    ri_zero;
		logic    ri_at_cnt;
		logic    ri_last;
		logic    r_gt_new;
		logic    r_id_hit;
		logic    pi_zero;
		logic    p_lt_new;
		logic    p_lt_earl;
		logic    tail_empty;
		logic    left_one;
		logic    pj_at_cnt;
		logic    out_free;
	} dp_sts_t;

endpackage

// File: hdl/dfr_ctrl.sv
// Sequencer for the deferred free reclaimer: walks the sorted tables step by step.
// Depends on dfr_pkg; drives dfr_dp through dp_cmd_t and reads dp_sts_t.
module dfr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_acc,
	input  dfr_pkg::dp_sts_t st,
	output dfr_pkg::dp_cmd_t cmd,
	output logic             idle
);
	import dfr_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) state_nx = ST_DISP;
			end
			ST_DISP: begin
				unique case (st.op)
					OPC_START: begin
						if (st.rfull) begin
							if (st.out_free) state_nx = ST_IDLE;
						end else begin
							state_nx = ST_RI_RD;
						end
					end
					OPC_FREE: begin
						if (st.rcnt_zero || st.pfull) begin
							if (st.out_free) state_nx = ST_IDLE;
						end else begin
							state_nx = ST_PI_RD;
						end
					end
					OPC_END: state_nx = ST_E_RD;
					OPC_RSVD: begin
						if (st.out_free) state_nx = ST_IDLE;
					end
					default: state_nx = ST_IDLE;
				endcase
			end
			ST_RI_RD:  state_nx = st.ri_zero ? ST_RI_WR : ST_RI_CMP;
			ST_RI_CMP: state_nx = st.r_gt_new ? ST_RI_RD : ST_RI_WR;
			ST_RI_WR: begin
				if (st.out_free) state_nx = ST_IDLE;
			end
			ST_PI_RD:  state_nx = st.pi_zero ? ST_PI_WR : ST_PI_CMP;
			ST_PI_CMP: state_nx = st.p_lt_new ? ST_PI_RD : ST_PI_WR;
			ST_PI_WR: begin
				if (st.out_free) state_nx = ST_IDLE;
			end
			ST_E_RD:     state_nx = st.ri_at_cnt ? ST_E_EARL : ST_E_CMP;
			ST_E_CMP:    state_nx = st.r_id_hit ? ST_E_DEL : ST_E_RD;
			ST_E_DEL:    state_nx = st.ri_last ? ST_E_EARL : ST_E_DEL_WR;
			ST_E_DEL_WR: state_nx = ST_E_DEL;
			ST_E_EARL: begin
				if (!st.rcnt_zero) begin
					state_nx = ST_E_EARL_LD;
				end else if (st.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			ST_E_EARL_LD: state_nx = ST_P_SCAN;
			ST_P_SCAN:    state_nx = st.pi_zero ? ST_P_CNT : ST_P_SCMP;
			ST_P_SCMP:    state_nx = st.p_lt_earl ? ST_P_SCAN : ST_P_CNT;
			ST_P_CNT: begin
				if (!st.tail_empty) begin
					state_nx = ST_P_RD;
				end else if (st.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			ST_P_RD: state_nx = ST_P_EMIT;
			ST_P_EMIT: begin
				if (st.out_free) state_nx = st.left_one ? ST_P_CP : ST_P_RD;
			end
			ST_P_CP:  state_nx = st.pj_at_cnt ? ST_IDLE : ST_P_CPW;
			ST_P_CPW: state_nx = ST_P_CP;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.op       = DP_NOP;
		cmd.e_status = STS_OK;
		cmd.e_hsel   = HS_ZERO;
		cmd.e_last   = 1'b1;
		idle         = 1'b0;
		unique case (state_q)
			ST_IDLE: idle = 1'b1;
			ST_DISP: begin
				unique case (st.op)
					OPC_START: begin
						if (st.rfull) begin
							cmd.emit     = st.out_free;
							cmd.e_status = STS_RFULL;
						end
					end
					OPC_FREE: begin
						if (st.rcnt_zero) begin
							cmd.emit     = st.out_free;
							cmd.e_status = STS_REL;
							cmd.e_hsel   = HS_IN;
						end else if (st.pfull) begin
							cmd.emit     = st.out_free;
							cmd.e_status = STS_PFULL;
						end
					end
					OPC_END: ;
					OPC_RSVD: cmd.emit = st.out_free;
					default: ;
				endcase
			end
			ST_RI_RD: begin
				if (!st.ri_zero) cmd.op = DP_R_RD_PREV;
			end
			ST_RI_CMP: begin
				if (st.r_gt_new) cmd.op = DP_R_SHIFT;
			end
			ST_RI_WR: begin
				if (st.out_free) begin
					cmd.op   = DP_R_INS;
					cmd.emit = 1'b1;
				end
			end
			ST_PI_RD: begin
				if (!st.pi_zero) cmd.op = DP_P_RD_PREV;
			end
			ST_PI_CMP: begin
				if (st.p_lt_new) cmd.op = DP_P_SHIFT;
			end
			ST_PI_WR: begin
				if (st.out_free) begin
					cmd.op   = DP_P_INS;
					cmd.emit = 1'b1;
				end
			end
			ST_E_RD: begin
				if (!st.ri_at_cnt) cmd.op = DP_R_RD;
			end
			ST_E_CMP: begin
				if (!st.r_id_hit) cmd.op = DP_R_NEXT;
			end
			ST_E_DEL:    cmd.op = st.ri_last ? DP_R_DEC : DP_R_RD_NEXT;
			ST_E_DEL_WR: cmd.op = DP_R_PULL;
			ST_E_EARL: begin
				if (!st.rcnt_zero) begin
					cmd.op = DP_R_RD0;
				end else begin
					cmd.emit = st.out_free;
				end
			end
			ST_E_EARL_LD: cmd.op = DP_EARL;
			ST_P_SCAN: begin
				if (!st.pi_zero) cmd.op = DP_P_RD_PREV;
			end
			ST_P_SCMP: begin
				if (st.p_lt_earl) cmd.op = DP_P_DEC;
			end
			ST_P_CNT: begin
				if (!st.tail_empty) begin
					cmd.op = DP_P_SETN;
				end else begin
					cmd.emit = st.out_free;
				end
			end
			ST_P_RD: cmd.op = DP_P_RD;
			ST_P_EMIT: begin
				if (st.out_free) begin
					cmd.op       = DP_P_EMIT;
					cmd.emit     = 1'b1;
					cmd.e_status = STS_REL;
					cmd.e_hsel   = HS_MEM;
					cmd.e_last   = st.left_one;
				end
			end
			ST_P_CP:  cmd.op = st.pj_at_cnt ? DP_P_TRIM : DP_P_RD;
			ST_P_CPW: cmd.op = DP_P_PULL;
			default: ;
		endcase
	end

endmodule

// File: hdl/dfr_dp.sv
// Datapath: reader and pending tables, counters, walk indexes and result register.
// Depends on dfr_pkg; commanded by dfr_ctrl.
module dfr_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_acc,
	input  logic [1:0]                  opcode,
	input  logic [dfr_pkg::ID_W-1:0]    reader_id,
	input  logic [dfr_pkg::STEP_W-1:0]  step,
	input  logic [dfr_pkg::HDL_W-1:0]   handle,
	input  dfr_pkg::dp_cmd_t            cmd,
	output dfr_pkg::dp_sts_t            st,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [dfr_pkg::HDL_W-1:0]   released_handle,
	output logic                        last
);
	import dfr_pkg::*;

	rrow_t rmem [READER_DEPTH];
	prow_t pmem [PENDING_DEPTH];
	rrow_t rrd_q;
	prow_t prd_q;

	opcode_t           op_q;
	logic [ID_W-1:0]   id_q;
	logic [STEP_W-1:0] step_q;
	logic [HDL_W-1:0]  hdl_q;
	logic [STEP_W-1:0] earl_q;

	logic [RCW-1:0] rcnt_q, ri_q;
	logic [PCW-1:0] pcnt_q, pi_q, pj_q, n_q, left_q;

	logic [RCW-1:0] ri_m1, ri_p1;
	logic [PCW-1:0] pi_m1, avail, n_nx;
	logic [RIW-1:0] r_raddr;
	logic [PIW-1:0] p_raddr;
	logic           r_rd, p_rd;

	logic           ov_q, olast_q;
	status_t        osts_q;
	logic [HDL_W-1:0] ohdl_q;

	assign ri_m1 = ri_q - 1'b1;
	assign ri_p1 = ri_q + 1'b1;
	assign pi_m1 = pi_q - 1'b1;
	assign avail = pcnt_q - pi_q;
	assign n_nx  = (avail > PCW'(MAX_RESULTS)) ? PCW'(MAX_RESULTS) : avail;

	always_comb begin
		r_rd    = 1'b0;
		r_raddr = ri_q[RIW-1:0];
		p_rd    = 1'b0;
		p_raddr = pj_q[PIW-1:0];
		unique case (cmd.op)
			DP_R_RD_PREV: begin
				r_rd    = 1'b1;
				r_raddr = ri_m1[RIW-1:0];
			end
			DP_R_RD: r_rd = 1'b1;
			DP_R_RD_NEXT: begin
				r_rd    = 1'b1;
				r_raddr = ri_p1[RIW-1:0];
			end
			DP_R_RD0: begin
				r_rd    = 1'b1;
				r_raddr = '0;
			end
			DP_P_RD_PREV: begin
				p_rd    = 1'b1;
				p_raddr = pi_m1[PIW-1:0];
			end
			DP_P_RD: p_rd = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (r_rd) rrd_q <= rmem[r_raddr];
		if (cmd.op == DP_R_SHIFT || cmd.op == DP_R_PULL) begin
			rmem[ri_q[RIW-1:0]] <= rrd_q;
		end else if (cmd.op == DP_R_INS) begin
			rmem[ri_q[RIW-1:0]] <= '{id: id_q, step: step_q};
		end
	end

	always_ff @(posedge clk) begin
		if (p_rd) prd_q <= pmem[p_raddr];
		if (cmd.op == DP_P_SHIFT || cmd.op == DP_P_PULL) begin
			pmem[pi_q[PIW-1:0]] <= prd_q;
		end else if (cmd.op == DP_P_INS) begin
			pmem[pi_q[PIW-1:0]] <= '{step: step_q, hdl: hdl_q};
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= opcode_t'(opcode);
			id_q   <= reader_id;
			step_q <= step;
			hdl_q  <= handle;
		end
		if (cmd.op == DP_EARL) earl_q <= rrd_q.step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= '0;
			pcnt_q <= '0;
			ri_q   <= '0;
			pi_q   <= '0;
			pj_q   <= '0;
			n_q    <= '0;
			left_q <= '0;
		end else begin
			if (in_acc) begin
				ri_q <= (opcode_t'(opcode) == OPC_END) ? '0 : rcnt_q;
				pi_q <= pcnt_q;
			end
			unique case (cmd.op)
				DP_R_SHIFT: ri_q <= ri_m1;
				DP_R_INS:   rcnt_q <= rcnt_q + 1'b1;
				DP_P_SHIFT: pi_q <= pi_m1;
				DP_P_INS:   pcnt_q <= pcnt_q + 1'b1;
				DP_R_NEXT:  ri_q <= ri_p1;
				DP_R_PULL:  ri_q <= ri_p1;
				DP_R_DEC:   rcnt_q <= rcnt_q - 1'b1;
				DP_EARL:    pi_q <= pcnt_q;
				DP_P_DEC:   pi_q <= pi_m1;
				DP_P_SETN: begin
					pj_q   <= pi_q;
					n_q    <= n_nx;
					left_q <= n_nx;
				end
				DP_P_EMIT: begin
					pj_q   <= pj_q + 1'b1;
					left_q <= left_q - 1'b1;
				end
				DP_P_PULL: begin
					pi_q <= pi_q + 1'b1;
					pj_q <= pj_q + 1'b1;
				end
				DP_P_TRIM:  pcnt_q <= pcnt_q - n_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			osts_q  <= cmd.e_status;
			olast_q <= cmd.e_last;
			unique case (cmd.e_hsel)
				HS_IN:   ohdl_q <= hdl_q;
				HS_MEM:  ohdl_q <= prd_q.hdl;
				default: ohdl_q <= '0;
			endcase
		end
	end

	assign out_valid       = ov_q;
	assign status          = osts_q;
	assign released_handle = ohdl_q;
	assign last            = olast_q;

	always_comb begin
		st.op         = op_q;
		st.rcnt_zero  = (rcnt_q == '0);
		st.rfull      = (rcnt_q == RCW'(READER_DEPTH));
		st.pfull      = (pcnt_q == PCW'(PENDING_DEPTH));
		st.ri_zero    = (ri_q == '0);
		st.ri_at_cnt  = (ri_q == rcnt_q);
		st.ri_last    = (ri_p1 >= rcnt_q);
		st.r_gt_new   = (rrd_q.step > step_q);
		st.r_id_hit   = (rrd_q.id == id_q);
		st.pi_zero    = (pi_q == '0);
		st.p_lt_new   = (prd_q.step < step_q);
		st.p_lt_earl  = (prd_q.step < earl_q);
		st.tail_empty = (avail == '0);
		st.left_one   = (left_q == PCW'(1));
		st.pj_at_cnt  = (pj_q == pcnt_q);
		st.out_free   = !ov_q || out_ready;
	end

endmodule

// File: hdl/deferred_free_reclaimer.sv
// Top level of the deferred free reclaimer: sequencer plus table datapath.
// Depends on dfr_pkg, dfr_ctrl and dfr_dp.
//
// channel  signals                                     direction
// in       in_valid/in_ready, opcode reader_id step handle   sink
// out      out_valid/out_ready, status released_handle last  source
//
// One transaction in at a time; a start or free shifts entries one at a time to
// open its slot, and an end scans and shifts readers, scans pending entries,
// releases handles and compacts entries one at a time.
// All table walks go through one read port per table with registered read data.
// Reset clears counts and control; table contents are undefined until written.
// A stalled out channel holds the sequencer at its next result; in_ready is low
// until the whole transaction has been handled.
module deferred_free_reclaimer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  opcode,
	input  logic [dfr_pkg::ID_W-1:0]    reader_id,
	input  logic [dfr_pkg::STEP_W-1:0]  step,
	input  logic [dfr_pkg::HDL_W-1:0]   handle,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [dfr_pkg::HDL_W-1:0]   released_handle,
	output logic                        last
);
	import dfr_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t st;
	logic    in_acc;

	assign in_acc = in_valid && in_ready;

	dfr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.in_acc (in_acc),
		.st     (st),
		.cmd    (cmd),
		.idle   (in_ready)
	);

	dfr_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_acc          (in_acc),
		.opcode          (opcode),
		.reader_id       (reader_id),
		.step            (step),
		.handle          (handle),
		.cmd             (cmd),
		.st              (st),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.released_handle (released_handle),
		.last            (last)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input taken twice in a row");

	a_zero_handle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STS_REL) |-> released_handle == '0)
		else $error("handle leaked on non-release result");

	a_full_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STS_RFULL || status == STS_PFULL) |-> last)
		else $error("table full result not last");

	a_no_emit_while_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || out_ready))
		else $error("result overwritten");

endmodule

// File: tb/tb_deferred_free_reclaimer.sv
// Testbench for deferred_free_reclaimer: directed and random reader/free traffic,
// checked against an in-bench model of the reader and pending-free tables.
// Depends on dfr_pkg and the deferred_free_reclaimer RTL.
`timescale 1ns / 1ps

module tb_deferred_free_reclaimer;
	import dfr_pkg::*;

	typedef struct packed {
		opcode_t           op;
		logic [ID_W-1:0]   id;
		logic [STEP_W-1:0] stp;
		logic [HDL_W-1:0]  hdl;
	} req_t;

	typedef struct packed {
		status_t          sts;
		logic [HDL_W-1:0] hdl;
		logic             lst;
	} rel_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        opcode = '0;
	logic [ID_W-1:0]   reader_id = '0;
	logic [STEP_W-1:0] step = '0;
	logic [HDL_W-1:0]  handle = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [1:0]        status;
	logic [HDL_W-1:0]  released_handle;
	logic              last;

	deferred_free_reclaimer dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [STEP_W-1:0] rd_step [READER_DEPTH];
	logic [ID_W-1:0]   rd_id [READER_DEPTH];
	int                rd_cnt = 0;
	logic [STEP_W-1:0] pf_step [PENDING_DEPTH];
	logic [HDL_W-1:0]  pf_hdl [PENDING_DEPTH];
	int                pf_cnt = 0;

	req_t pending_reqs[$];
	rel_t expected_rels[$];
	int   errors = 0;
	int   sent = 0;
	int   hold_cycles = 0;
	logic hold_done = 1'b0;
	logic stim_done = 1'b0;
	logic [ID_W-1:0] live_ids[$];

	function automatic rel_t mk(status_t s, logic [HDL_W-1:0] h, logic l);
		rel_t r;
		r.sts = s;
		r.hdl = h;
		r.lst = l;
		return r;
	endfunction

	task automatic predict_reclaim(input req_t q);
		int pos, k, n, j;
		logic [STEP_W-1:0] earliest;
		case (q.op)
			OPC_START: begin
				if (rd_cnt >= READER_DEPTH) begin
					expected_rels.push_back(mk(STS_RFULL, '0, 1'b1));
				end else begin
					pos = 0;
					while (pos < rd_cnt && rd_step[pos] <= q.stp) pos++;
					for (j = rd_cnt; j > pos; j--) begin
						rd_step[j] = rd_step[j-1];
						rd_id[j] = rd_id[j-1];
					end
					rd_step[pos] = q.stp;
					rd_id[pos] = q.id;
					rd_cnt++;
					expected_rels.push_back(mk(STS_OK, '0, 1'b1));
				end
			end
			OPC_END: begin
				for (j = 0; j < rd_cnt; j++) begin
					if (rd_id[j] == q.id) begin
						for (k = j; k + 1 < rd_cnt; k++) begin
							rd_step[k] = rd_step[k+1];
							rd_id[k] = rd_id[k+1];
						end
						rd_cnt--;
						break;
					end
				end
				earliest = (rd_cnt > 0) ? rd_step[0] : '0;
				k = 0;
				while (k < pf_cnt && !(pf_step[k] < earliest)) k++;
				n = pf_cnt - k;
				if (n > MAX_RESULTS) n = MAX_RESULTS;
				if (n == 0) begin
					expected_rels.push_back(mk(STS_OK, '0, 1'b1));
				end else begin
					for (j = 0; j < n; j++)
						expected_rels.push_back(mk(STS_REL, pf_hdl[k+j], j + 1 == n));
					for (j = k; j + n < pf_cnt; j++) begin
						pf_step[j] = pf_step[j+n];
						pf_hdl[j] = pf_hdl[j+n];
					end
					pf_cnt -= n;
				end
			end
			OPC_FREE: begin
				if (rd_cnt == 0) begin
					expected_rels.push_back(mk(STS_REL, q.hdl, 1'b1));
				end else if (pf_cnt >= PENDING_DEPTH) begin
					expected_rels.push_back(mk(STS_PFULL, '0, 1'b1));
				end else begin
					pos = 0;
					while (pos < pf_cnt && pf_step[pos] >= q.stp) pos++;
					for (j = pf_cnt; j > pos; j--) begin
						pf_step[j] = pf_step[j-1];
						pf_hdl[j] = pf_hdl[j-1];
					end
					pf_step[pos] = q.stp;
					pf_hdl[pos] = q.hdl;
					pf_cnt++;
					expected_rels.push_back(mk(STS_OK, '0, 1'b1));
				end
			end
			default: expected_rels.push_back(mk(STS_OK, '0, 1'b1));
		endcase
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] small_step();
		return 64'($urandom_range(0, 40));
	endfunction

	task automatic add_req(opcode_t o, logic [ID_W-1:0] i, logic [63:0] s, logic [63:0] h);
		req_t q;
		q.op = o;
		q.id = i;
		q.stp = s;
		q.hdl = h;
		pending_reqs.push_back(q);
	endtask

	// driver
	int in_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_reclaim('{opcode_t'(opcode), reader_id, step, handle});
				sent++;
				in_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			end
			if (!(in_valid && !in_ready)) begin
				if (in_gap > 0 || pending_reqs.size() == 0) begin
					if (in_gap > 0) in_gap--;
					in_valid <= 1'b0;
				end else begin
					req_t q;
					q = pending_reqs.pop_front();
					in_valid <= 1'b1;
					opcode <= q.op;
					reader_id <= q.id;
					step <= q.stp;
					handle <= q.hdl;
				end
			end
		end
	end

	// monitor and receiver stall
	int out_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				rel_t e;
				if (expected_rels.size() == 0) begin
					$display("%0t: unexpected transaction status=%0d handle=%h last=%0d",
						$time, status, released_handle, last);
					errors++;
				end else begin
					e = expected_rels.pop_front();
					if (status !== e.sts) begin
						$display("%0t: status expected %0d actual %0d", $time, e.sts, status);
						errors++;
					end
					if (released_handle !== e.hdl) begin
						$display("%0t: handle expected %h actual %h", $time, e.hdl,
							released_handle);
						errors++;
					end
					if (last !== e.lst) begin
						$display("%0t: last expected %0d actual %0d", $time, e.lst, last);
						errors++;
					end
				end
				out_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else if (sent >= 120 && !hold_done && !stim_done) begin
				hold_done = 1'b1;
				hold_cycles = 600;
				out_ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > 1000000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [ID_W-1:0] rid;
		int r;
		// directed
		add_req(OPC_FREE, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		add_req(OPC_END, 16'hFFFF, '0, '0);
		add_req(OPC_START, 16'hFFFF, 64'd10, '0);
		add_req(OPC_START, 16'h0001, 64'd10, '0);
		add_req(OPC_START, 16'h0002, 64'hFFFF_FFFF_FFFF_FFFF, '0);
		add_req(OPC_FREE, '0, 64'd5, 64'h1111);
		add_req(OPC_FREE, '0, 64'd5, 64'h2222);
		add_req(OPC_FREE, '0, 64'd0, 64'h3333);
		add_req(OPC_FREE, '0, 64'd20, 64'h4444);
		add_req(OPC_RSVD, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		add_req(OPC_END, 16'h1234, '0, '0);
		add_req(OPC_END, 16'hFFFF, '0, '0);
		add_req(OPC_END, 16'h0001, '0, '0);
		add_req(OPC_END, 16'h0002, '0, '0);
		for (int i = 0; i < 17; i++) add_req(OPC_START, 16'(i), 64'(i % 3), '0);
		for (int i = 0; i < 33; i++) add_req(OPC_FREE, '0, 64'($urandom_range(0, 3)), rnd64());
		for (int i = 0; i < 16; i++) add_req(OPC_END, 16'(i), '0, '0);
		for (int i = 0; i < 3; i++) add_req(OPC_START, 16'(100 + i), 64'd50, '0);
		add_req(OPC_START, 16'd200, 64'd60, '0);
		for (int i = 0; i < 34; i++) add_req(OPC_FREE, '0, 64'(i), rnd64());
		add_req(OPC_END, 16'd100, '0, '0);
		add_req(OPC_END, 16'd101, '0, '0);
		add_req(OPC_END, 16'd102, '0, '0);
		add_req(OPC_END, 16'd999, '0, '0);
		add_req(OPC_END, 16'd200, '0, '0);
		// random: mostly structured reader lifecycles with small steps
		for (int i = 0; i < 130; i++) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				rid = 16'($urandom_range(0, 20));
				if (r < 3) rid = 16'($urandom());
				live_ids.push_back(rid);
				add_req(OPC_START, rid, (r < 5) ? rnd64() : small_step(), '0);
			end else if (r < 55) begin
				if (live_ids.size() > 0 && r < 52) begin
					int idx;
					idx = $urandom_range(0, live_ids.size() - 1);
					rid = live_ids[idx];
					live_ids.delete(idx);
				end else begin
					rid = 16'($urandom());
				end
				add_req(OPC_END, rid, rnd64(), rnd64());
			end else if (r < 97) begin
				add_req(OPC_FREE, 16'($urandom()), (r < 60) ? rnd64() : small_step(), rnd64());
			end else begin
				add_req(OPC_RSVD, 16'($urandom()), rnd64(), rnd64());
			end
		end
		// drain every reader so the tail gets released
		foreach (live_ids[j]) add_req(OPC_END, live_ids[j], '0, '0);
		#95 arst_n = 1'b1;
		wait (pending_reqs.size() == 0 && !in_valid);
		stim_done = 1'b1;
		wait (expected_rels.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_rels.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
